// ----- sv/hclr_pkg.sv -----
// Shared constants for the handle cache with oldest-stamp replacement.
`timescale 1ns / 1ps

package hclr_pkg;

  // Cache geometry
  localparam int unsigned ENTRIES = 2;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths
  localparam int unsigned ID_W     = 64;
  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned STAMP_W  = 64;

  // Command codes
  localparam logic [1:0] CMD_TAKE      = 2'd0;
  localparam logic [1:0] CMD_STORE     = 2'd1;
  localparam logic [1:0] CMD_INVAL     = 2'd2;
  localparam logic [1:0] CMD_INVAL_ALL = 2'd3;

endpackage

// ----- sv/handle_cache_lru_replace.sv -----
// Fully associative handle cache: take, store with oldest-stamp eviction, invalidation.
// A scan checks the entries in index order with one shared 128-bit identifier compare and
//   64-bit stamp compare, one entry per cycle, held while an invalidate-all waits on a full output.
// Commands: one at a time; in_ready_o is low from an accept until the command's last
//   result word is registered, which an output stall delays.
// Reset: asynchronous, active low; all entries empty, stamp counter zero, no word pending.
`timescale 1ns / 1ps

module handle_cache_lru_replace (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] id_high_i,
  input  logic [63:0] id_low_i,
  input  logic [63:0] handle_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [63:0] handle_out_o,
  output logic        closed_o,
  output logic [63:0] closed_handle_o,
  output logic        last_o
);

  localparam int unsigned EN = hclr_pkg::ENTRIES;
  localparam int unsigned IW = hclr_pkg::IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // Entry storage
  logic [hclr_pkg::ID_W-1:0]     id_high_q [EN];
  logic [hclr_pkg::ID_W-1:0]     id_low_q  [EN];
  logic [hclr_pkg::HANDLE_W-1:0] handle_q  [EN];
  logic [hclr_pkg::STAMP_W-1:0]  stamp_q   [EN];
  logic [EN-1:0]                 valid_q, valid_d;
  logic [hclr_pkg::STAMP_W-1:0]  next_stamp_q, next_stamp_d;

  // Sequencer state
  logic [1:0]                    state_q, state_d;
  logic [1:0]                    cmd_q, cmd_d;
  logic [hclr_pkg::ID_W-1:0]     key_hi_q, key_hi_d, key_lo_q, key_lo_d;
  logic [hclr_pkg::HANDLE_W-1:0] hin_q, hin_d;
  logic [IW-1:0]                 idx_q, idx_d;
  logic                          found_q, found_d;
  logic [IW-1:0]                 sel_idx_q, sel_idx_d;
  logic [hclr_pkg::HANDLE_W-1:0] sel_handle_q, sel_handle_d;
  logic                          cand_valid_q, cand_valid_d;
  logic [IW-1:0]                 cand_idx_q, cand_idx_d;
  logic [hclr_pkg::STAMP_W-1:0]  cand_stamp_q, cand_stamp_d;
  logic [hclr_pkg::HANDLE_W-1:0] cand_handle_q, cand_handle_d;
  logic                          emitted_q, emitted_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic                          hit_q, hit_d, closed_q, closed_d, last_q, last_d;
  logic [hclr_pkg::HANDLE_W-1:0] hout_q, hout_d, chandle_q, chandle_d;

  // Shared unit and scan helpers
  logic          cur_valid, id_eq, stamp_lt, scan_last, any_later, out_free;
  logic [EN-1:0] above_mask;
  logic          wr_en;
  logic [IW-1:0] wr_idx;

  assign cur_valid = valid_q[idx_q];
  assign id_eq     = (id_high_q[idx_q] == key_hi_q) && (id_low_q[idx_q] == key_lo_q);
  assign stamp_lt  = stamp_q[idx_q] < cand_stamp_q;
  assign scan_last = (idx_q == IW'(EN - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  // Mark entries above the scan index
  always_comb begin
    for (int i = 0; i < EN; i++) begin
      above_mask[i] = (IW'(i) > idx_q);
    end
  end
  assign any_later = |(valid_q & above_mask);

  // Sequencer
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    key_hi_d      = key_hi_q;
    key_lo_d      = key_lo_q;
    hin_d         = hin_q;
    idx_d         = idx_q;
    found_d       = found_q;
    sel_idx_d     = sel_idx_q;
    sel_handle_d  = sel_handle_q;
    cand_valid_d  = cand_valid_q;
    cand_idx_d    = cand_idx_q;
    cand_stamp_d  = cand_stamp_q;
    cand_handle_d = cand_handle_q;
    emitted_d     = emitted_q;
    valid_d       = valid_q;
    next_stamp_d  = next_stamp_q;
    wr_en         = 1'b0;
    wr_idx        = cand_idx_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    hit_d         = hit_q;
    hout_d        = hout_q;
    closed_d      = closed_q;
    chandle_d     = chandle_q;
    last_d        = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          key_hi_d     = id_high_i;
          key_lo_d     = id_low_i;
          hin_d        = handle_in_i;
          idx_d        = '0;
          found_d      = 1'b0;
          cand_valid_d = 1'b0;
          emitted_d    = 1'b0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        case (cmd_q)
          hclr_pkg::CMD_TAKE, hclr_pkg::CMD_INVAL: begin
            // Stop at the lowest matching entry
            if (cur_valid && id_eq) begin
              found_d      = 1'b1;
              sel_idx_d    = idx_q;
              sel_handle_d = handle_q[idx_q];
              state_d      = ST_EMIT;
            end else if (scan_last) begin
              state_d = ST_EMIT;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
          hclr_pkg::CMD_STORE: begin
            // Take the lowest free entry, else track the oldest stamp
            if (!cur_valid) begin
              found_d   = 1'b1;
              sel_idx_d = idx_q;
              state_d   = ST_EMIT;
            end else begin
              if (!cand_valid_q || stamp_lt) begin
                cand_valid_d  = 1'b1;
                cand_idx_d    = idx_q;
                cand_stamp_d  = stamp_q[idx_q];
                cand_handle_d = handle_q[idx_q];
              end
              if (scan_last) begin
                state_d = ST_EMIT;
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
          end
          default: begin
            // Invalidate all: one word per valid entry, or one empty word if none is valid; hold while output is full
            if (out_free) begin
              if (cur_valid) begin
                out_valid_d    = 1'b1;
                hit_d          = 1'b0;
                hout_d         = '0;
                closed_d       = 1'b1;
                chandle_d      = handle_q[idx_q];
                last_d         = !any_later;
                valid_d[idx_q] = 1'b0;
                emitted_d      = 1'b1;
              end else if (scan_last && !emitted_q) begin
                out_valid_d = 1'b1;
                hit_d       = 1'b0;
                hout_d      = '0;
                closed_d    = 1'b0;
                chandle_d   = '0;
                last_d      = 1'b1;
              end
              if (scan_last) begin
                state_d = ST_IDLE;
              end else begin
                idx_d = idx_q + IW'(1);
              end
            end
          end
        endcase
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = 1'b0;
          hout_d      = '0;
          closed_d    = 1'b0;
          chandle_d   = '0;
          last_d      = 1'b1;
          case (cmd_q)
            hclr_pkg::CMD_TAKE: begin
              hit_d = found_q;
              if (found_q) begin
                hout_d             = sel_handle_q;
                valid_d[sel_idx_q] = 1'b0;
              end
            end
            hclr_pkg::CMD_INVAL: begin
              closed_d = found_q;
              if (found_q) begin
                chandle_d          = sel_handle_q;
                valid_d[sel_idx_q] = 1'b0;
              end
            end
            default: begin
              // Store: write the chosen entry, report the evicted handle
              wr_en           = 1'b1;
              wr_idx          = found_q ? sel_idx_q : cand_idx_q;
              valid_d[wr_idx] = (key_hi_q | key_lo_q) != '0;
              next_stamp_d    = next_stamp_q + hclr_pkg::STAMP_W'(1);
              closed_d        = !found_q;
              chandle_d       = found_q ? '0 : cand_handle_q;
            end
          endcase
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      next_stamp_q <= '0;
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      cand_valid_q <= 1'b0;
      emitted_q    <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      next_stamp_q <= next_stamp_d;
      out_valid_q  <= out_valid_d;
      found_q      <= found_d;
      cand_valid_q <= cand_valid_d;
      emitted_q    <= emitted_d;
      idx_q        <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    key_hi_q      <= key_hi_d;
    key_lo_q      <= key_lo_d;
    hin_q         <= hin_d;
    sel_idx_q     <= sel_idx_d;
    sel_handle_q  <= sel_handle_d;
    cand_idx_q    <= cand_idx_d;
    cand_stamp_q  <= cand_stamp_d;
    cand_handle_q <= cand_handle_d;
    hit_q         <= hit_d;
    hout_q        <= hout_d;
    closed_q      <= closed_d;
    chandle_q     <= chandle_d;
    last_q        <= last_d;
  end

  // Entry write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_high_q[wr_idx] <= key_hi_q;
      id_low_q[wr_idx]  <= key_lo_q;
      handle_q[wr_idx]  <= hin_q;
      stamp_q[wr_idx]   <= next_stamp_q;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign handle_out_o    = hout_q;
  assign closed_o        = closed_q;
  assign closed_handle_o = chandle_q;
  assign last_o          = last_q;

`ifndef NO_ASSERTIONS
  // Eviction only happens with every entry in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cmd_q == hclr_pkg::CMD_STORE && !found_q) |-> (&valid_q))
    else $error("store evicts while a free entry exists");

  // Invalidate-all leaves the cache empty once its scan completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmd_q == hclr_pkg::CMD_INVAL_ALL && scan_last && out_free)
    |=> (valid_q == '0))
    else $error("entries remain valid after invalidate-all");

  // A take hit frees its entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cmd_q == hclr_pkg::CMD_TAKE && found_q && out_free)
    |=> !valid_q[$past(sel_idx_q)])
    else $error("take hit did not free its entry");

  // Each store advances the stamp counter by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cmd_q == hclr_pkg::CMD_STORE && out_free)
    |=> (next_stamp_q == $past(next_stamp_q) + hclr_pkg::STAMP_W'(1)))
    else $error("stamp counter did not advance on store");
`endif

endmodule

// ----- tb/sv/tb_handle_cache_lru_replace.sv -----
// Testbench for the handle cache: predicts reply words per command and checks them in order.
`timescale 1ns / 1ps

module tb_handle_cache_lru_replace;

  localparam int LIMIT     = 1000000;
  localparam int RAND_CMDS = 1250;
  localparam int POOL_N    = 5;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic [hclr_pkg::ID_W-1:0]     id_hi;
    logic [hclr_pkg::ID_W-1:0]     id_lo;
    logic [hclr_pkg::HANDLE_W-1:0] handle;
    logic                          drain;
  } cmd_word_t;

  typedef struct packed {
    logic                          hit;
    logic [hclr_pkg::HANDLE_W-1:0] handle;
    logic                          closed;
    logic [hclr_pkg::HANDLE_W-1:0] closed_handle;
    logic                          last;
  } reply_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic [1:0]                    command_i    = hclr_pkg::CMD_TAKE;
  logic [hclr_pkg::ID_W-1:0]     id_high_i    = '0;
  logic [hclr_pkg::ID_W-1:0]     id_low_i     = '0;
  logic [hclr_pkg::HANDLE_W-1:0] handle_in_i  = '0;
  logic                          out_ready_i  = 1'b0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic                          hit_o;
  logic [hclr_pkg::HANDLE_W-1:0] handle_out_o;
  logic                          closed_o;
  logic [hclr_pkg::HANDLE_W-1:0] closed_handle_o;
  logic                          last_o;

  // Pending command words and the reply words they are due to cause
  cmd_word_t cmd_words[$];
  reply_t    due_words[$];
  cmd_word_t cur_word;
  cmd_word_t nxt_word;

  // Shadow copy of the cache contents
  logic [hclr_pkg::ID_W-1:0]     m_id_hi [hclr_pkg::ENTRIES];
  logic [hclr_pkg::ID_W-1:0]     m_id_lo [hclr_pkg::ENTRIES];
  logic [hclr_pkg::HANDLE_W-1:0] m_handle[hclr_pkg::ENTRIES];
  logic [hclr_pkg::STAMP_W-1:0]  m_stamp [hclr_pkg::ENTRIES];
  logic [hclr_pkg::STAMP_W-1:0]  m_next_stamp;

  logic [hclr_pkg::ID_W-1:0] pool_hi[POOL_N];
  logic [hclr_pkg::ID_W-1:0] pool_lo[POOL_N];

  int sent_cnt  = 0;
  int rx_cnt    = 0;
  int err_cnt   = 0;
  int tx_gap    = 0;
  int rx_stall  = 0;
  int rx_hold   = 0;
  int cycle_cnt = 0;
  bit hold_done = 1'b0;

  handle_cache_lru_replace i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .id_high_i       (id_high_i),
    .id_low_i        (id_low_i),
    .handle_in_i     (handle_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .handle_out_o    (handle_out_o),
    .closed_o        (closed_o),
    .closed_handle_o (closed_handle_o),
    .last_o          (last_o)
  );

  // Run the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic bit entry_used(int i);
    return (m_id_hi[i] | m_id_lo[i]) != '0;
  endfunction

  // Lowest-index match; the empty identifier never matches
  function automatic int find_entry(logic [hclr_pkg::ID_W-1:0] hi,
                                    logic [hclr_pkg::ID_W-1:0] lo);
    if ((hi | lo) == '0) return -1;
    for (int i = 0; i < hclr_pkg::ENTRIES; i++) begin
      if (m_id_hi[i] == hi && m_id_lo[i] == lo) return i;
    end
    return -1;
  endfunction

  // Update the shadow cache for one command and queue the replies it causes
  function automatic void apply_command(cmd_word_t w);
    int     slot;
    int     used_n;
    int     k;
    reply_t r;
    slot   = -1;
    used_n = 0;
    k      = 0;
    r      = '0;
    r.last = 1'b1;
    case (w.cmd)
      hclr_pkg::CMD_TAKE, hclr_pkg::CMD_INVAL: begin
        slot = find_entry(w.id_hi, w.id_lo);
        if (slot >= 0) begin
          m_id_hi[slot] = '0;
          m_id_lo[slot] = '0;
          if (w.cmd == hclr_pkg::CMD_TAKE) begin
            r.hit    = 1'b1;
            r.handle = m_handle[slot];
          end else begin
            r.closed        = 1'b1;
            r.closed_handle = m_handle[slot];
          end
        end
        due_words.push_back(r);
      end
      hclr_pkg::CMD_STORE: begin
        for (int i = 0; i < hclr_pkg::ENTRIES; i++) begin
          if (slot < 0 && !entry_used(i)) slot = i;
        end
        // Full: evict the oldest stamp, lowest index on a tie
        if (slot < 0) begin
          slot = 0;
          for (int i = 1; i < hclr_pkg::ENTRIES; i++) begin
            if (m_stamp[i] < m_stamp[slot]) slot = i;
          end
          r.closed        = 1'b1;
          r.closed_handle = m_handle[slot];
        end
        m_id_hi[slot]  = w.id_hi;
        m_id_lo[slot]  = w.id_lo;
        m_handle[slot] = w.handle;
        m_stamp[slot]  = m_next_stamp;
        m_next_stamp   = m_next_stamp + 1'b1;
        due_words.push_back(r);
      end
      default: begin
        for (int i = 0; i < hclr_pkg::ENTRIES; i++) begin
          if (entry_used(i)) used_n++;
        end
        if (used_n == 0) begin
          due_words.push_back(r);
        end else begin
          for (int i = 0; i < hclr_pkg::ENTRIES; i++) begin
            if (entry_used(i)) begin
              k++;
              r.closed        = 1'b1;
              r.closed_handle = m_handle[i];
              r.last          = (k == used_n);
              due_words.push_back(r);
              m_id_hi[i] = '0;
              m_id_lo[i] = '0;
            end
          end
        end
      end
    endcase
  endfunction

  function automatic void add_word(logic [1:0] cmd, logic [63:0] hi, logic [63:0] lo,
                                   logic [63:0] h, logic drain);
    cmd_word_t w;
    w.cmd    = cmd;
    w.id_hi  = hi;
    w.id_lo  = lo;
    w.handle = h;
    w.drain  = drain;
    cmd_words.push_back(w);
  endfunction

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  // Compare one reply word against the oldest due word
  function automatic void check_word();
    reply_t got;
    reply_t want;
    got.hit           = hit_o;
    got.handle        = handle_out_o;
    got.closed        = closed_o;
    got.closed_handle = closed_handle_o;
    got.last          = last_o;
    if (due_words.size() == 0) begin
      flag_error($sformatf("unexpected word hit=%0b h=%h cl=%0b ch=%h last=%0b",
                           got.hit, got.handle, got.closed, got.closed_handle, got.last));
    end else begin
      want = due_words.pop_front();
      if (got.hit !== want.hit || got.handle !== want.handle ||
          got.closed !== want.closed || got.closed_handle !== want.closed_handle ||
          got.last !== want.last) begin
        flag_error($sformatf({"word %0d: want hit=%0b h=%h cl=%0b ch=%h last=%0b, ",
                              "got hit=%0b h=%h cl=%0b ch=%h last=%0b"}, rx_cnt,
                             want.hit, want.handle, want.closed, want.closed_handle,
                             want.last, got.hit, got.handle, got.closed,
                             got.closed_handle, got.last));
      end
    end
  endfunction

  // Drive command words; predict replies at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      command_i   <= hclr_pkg::CMD_TAKE;
      id_high_i   <= '0;
      id_low_i    <= '0;
      handle_in_i <= '0;
      cur_word    <= '0;
      tx_gap      <= 0;
      sent_cnt    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_command(cur_word);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (cmd_words.size() != 0 &&
                     !(cmd_words[0].drain && (due_words.size() != 0 || in_valid_i))) begin
          nxt_word    = cmd_words.pop_front();
          cur_word    <= nxt_word;
          command_i   <= nxt_word.cmd;
          id_high_i   <= nxt_word.id_hi;
          id_low_i    <= nxt_word.id_lo;
          handle_in_i <= nxt_word.handle;
          in_valid_i  <= 1'b1;
          // Run without gaps in some stretches
          tx_gap <= (((sent_cnt / 128) % 4) == 2) ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Accept and check reply words; stall at random, once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall    <= 0;
      rx_hold     <= 0;
      rx_cnt      <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_word();
        rx_cnt <= rx_cnt + 1;
      end
      if (rx_hold != 0) begin
        rx_hold     <= rx_hold - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && sent_cnt >= 400) begin
        rx_hold     <= 300;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall    <= rx_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_stall    <= (((rx_cnt / 128) % 4) == 1) ? 0 : pick_gap();
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // Build the stimulus, release reset, wait for the last reply
  initial begin
    logic [63:0] ones;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [1:0]  cmd;
    int          r;
    int          p;
    ones = '1;

    for (int i = 0; i < hclr_pkg::ENTRIES; i++) begin
      m_id_hi[i]  = '0;
      m_id_lo[i]  = '0;
      m_handle[i] = '0;
      m_stamp[i]  = '0;
    end
    m_next_stamp = '0;

    // Identifier pool: half-zero identifiers among them
    for (int i = 0; i < POOL_N; i++) begin
      pool_hi[i] = rand64();
      pool_lo[i] = rand64();
    end
    pool_hi[0] = '0;
    pool_lo[1] = '0;

    // Empty cache: misses, empty invalidate-all, empty identifier
    add_word(hclr_pkg::CMD_TAKE,      ones, ones, '0, 1'b0);
    add_word(hclr_pkg::CMD_INVAL_ALL, '0,   '0,   '0, 1'b0);
    add_word(hclr_pkg::CMD_TAKE,      '0,   '0,   '0, 1'b0);
    add_word(hclr_pkg::CMD_INVAL,     '0,   '0,   '0, 1'b0);
    // Fill, take, then evict the oldest twice
    add_word(hclr_pkg::CMD_STORE,     ones, ones, ones, 1'b0);
    add_word(hclr_pkg::CMD_STORE,     '0,   64'd1, '0,  1'b0);
    add_word(hclr_pkg::CMD_TAKE,      ones, ones, '0, 1'b0);
    add_word(hclr_pkg::CMD_STORE,     64'h8000_0000_0000_0000, '0,
             64'h5555_5555_5555_5555, 1'b0);
    add_word(hclr_pkg::CMD_STORE,     ones, ones, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_word(hclr_pkg::CMD_STORE,     '0,   64'd1, 64'h0123_4567_89ab_cdef, 1'b0);
    add_word(hclr_pkg::CMD_INVAL,     ones, ones, '0, 1'b0);
    // Store of the empty identifier leaves the entry free
    add_word(hclr_pkg::CMD_STORE,     '0,   '0,   64'hdead_beef_0000_0001, 1'b0);
    add_word(hclr_pkg::CMD_STORE,     ones, ones, 64'h0000_0000_ffff_ffff, 1'b0);
    add_word(hclr_pkg::CMD_INVAL_ALL, '0,   '0,   '0, 1'b0);
    // Duplicate identifiers: lowest index answers first; wait for an empty pipe
    add_word(hclr_pkg::CMD_STORE,     ones, ones, 64'h1111_1111_1111_1111, 1'b1);
    add_word(hclr_pkg::CMD_STORE,     ones, ones, 64'h2222_2222_2222_2222, 1'b0);
    add_word(hclr_pkg::CMD_TAKE,      ones, ones, '0, 1'b0);
    add_word(hclr_pkg::CMD_TAKE,      ones, ones, '0, 1'b0);
    add_word(hclr_pkg::CMD_TAKE,      ones, ones, '0, 1'b0);
    // Fill the cache, then use the empty identifier on each command kind
    add_word(hclr_pkg::CMD_STORE,     64'h8000_0000_0000_0000, '0,
             64'h3333_3333_3333_3333, 1'b0);
    add_word(hclr_pkg::CMD_STORE,     '0,   64'd1, 64'h4444_4444_4444_4444, 1'b0);
    add_word(hclr_pkg::CMD_INVAL,     '0,   '0,   '0, 1'b0);
    add_word(hclr_pkg::CMD_TAKE,      '0,   '0,   '0, 1'b0);
    add_word(hclr_pkg::CMD_STORE,     '0,   '0,   64'h7777_7777_7777_7777, 1'b0);
    add_word(hclr_pkg::CMD_INVAL_ALL, '0,   '0,   '0, 1'b0);

    // Random commands, mostly on a small identifier pool so hits and evictions recur
    for (int k = 0; k < RAND_CMDS; k++) begin
      r = $urandom_range(99);
      if (r < 35)      cmd = hclr_pkg::CMD_STORE;
      else if (r < 68) cmd = hclr_pkg::CMD_TAKE;
      else if (r < 92) cmd = hclr_pkg::CMD_INVAL;
      else             cmd = hclr_pkg::CMD_INVAL_ALL;
      r = $urandom_range(99);
      if (r < 6) begin
        hi = '0;
        lo = '0;
      end else if (r < 14) begin
        hi = rand64();
        lo = rand64();
      end else begin
        p  = $urandom_range(POOL_N - 1);
        hi = pool_hi[p];
        lo = pool_lo[p];
      end
      add_word(cmd, hi, lo, rand64(), k == 600);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_words.size() != 0 || in_valid_i || due_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
